>>> hw/rtl/wgm_pkg.sv
package wgm_pkg;

    localparam int MAX_PATTERN  = 64;
    localparam int LEN_W        = $clog2(MAX_PATTERN + 1);
    localparam int CLOSE_LEVELS = $clog2(MAX_PATTERN + 1);

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_APPEND = 2'd0;
    localparam t_kind KIND_NAME   = 2'd1;
    localparam t_kind KIND_END    = 2'd2;
    localparam t_kind KIND_CLEAR  = 2'd3;

    localparam logic [7:0] GLOB_ANY_ONE = 8'h3F;
    localparam logic [7:0] GLOB_ANY_RUN = 8'h2A;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_value;
    } t_item;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_result;

endpackage

>>> hw/rtl/wgm_star_close.sv
module wgm_star_close (
    input  logic [wgm_pkg::MAX_PATTERN:0]   i_seed,
    input  logic [wgm_pkg::MAX_PATTERN-1:0] i_star_mask,
    output logic [wgm_pkg::MAX_PATTERN:0]   o_closed
);
    import wgm_pkg::*;

    // Bit j+1 is forced whenever bit j is set and pattern byte j is a star.
    // This is a carry chain, resolved here as a parallel prefix network.
    logic [MAX_PATTERN:0] g_lvl [0:CLOSE_LEVELS];
    logic [MAX_PATTERN:0] p_lvl [0:CLOSE_LEVELS];

    always_comb begin
        g_lvl[0] = i_seed;
        p_lvl[0] = {i_star_mask, 1'b0};
        for (int l = 0; l < CLOSE_LEVELS; l++) begin
            for (int j = 0; j <= MAX_PATTERN; j++) begin
                if (j >= (1 << l)) begin
                    g_lvl[l+1][j] = g_lvl[l][j] | (p_lvl[l][j] & g_lvl[l][j - (1 << l)]);
                    p_lvl[l+1][j] = p_lvl[l][j] & p_lvl[l][j - (1 << l)];
                end else begin
                    g_lvl[l+1][j] = g_lvl[l][j];
                    p_lvl[l+1][j] = p_lvl[l][j];
                end
            end
        end
    end

    assign o_closed = g_lvl[CLOSE_LEVELS];

endmodule

>>> hw/rtl/wgm_core.sv
module wgm_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  wgm_pkg::t_item   i_item,
    output wgm_pkg::t_result o_result
);
    import wgm_pkg::*;

    logic [7:0]             r_pat [0:MAX_PATTERN-1];
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    logic                   r_ovf;
    logic                   n_ovf;
    logic [MAX_PATTERN:0]   r_seed;
    logic [MAX_PATTERN:0]   n_seed;
    logic [MAX_PATTERN-1:0] used;
    logic [MAX_PATTERN-1:0] star_mask;
    logic [MAX_PATTERN:0]   reach;
    logic [MAX_PATTERN:0]   stepped;
    logic                   room;
    logic [MAX_PATTERN:0]   rearm_seed;

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            used[i]      = LEN_W'(i) < r_len;
            star_mask[i] = used[i] && (r_pat[i] == GLOB_ANY_RUN);
        end
    end

    // The stored seed holds the reach bits before star closure.
    wgm_star_close u_close (
        .i_seed      (r_seed),
        .i_star_mask (star_mask),
        .o_closed    (reach)
    );

    always_comb begin
        stepped[0] = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (!used[i]) begin
                stepped[i+1] = 1'b0;
            end else if (r_pat[i] == GLOB_ANY_RUN) begin
                stepped[i+1] = reach[i] | reach[i+1];
            end else begin
                stepped[i+1] = reach[i] &&
                    ((r_pat[i] == GLOB_ANY_ONE) || (r_pat[i] == i_item.byte_value));
            end
        end
    end

    assign room       = r_len != LEN_W'(MAX_PATTERN);
    assign rearm_seed = (MAX_PATTERN + 1)'(1);

    always_comb begin
        n_len  = r_len;
        n_ovf  = r_ovf;
        n_seed = r_seed;
        if (i_en) begin
            unique case (i_item.kind)
                KIND_APPEND: begin
                    if (room) begin
                        n_len = r_len + LEN_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_seed = rearm_seed;
                end
                KIND_NAME: begin
                    n_seed = stepped;
                end
                KIND_END: begin
                    n_seed = rearm_seed;
                end
                KIND_CLEAR: begin
                    n_len  = '0;
                    n_ovf  = 1'b0;
                    n_seed = rearm_seed;
                end
                default: begin
                    n_seed = r_seed;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_seed <= rearm_seed;
        end else begin
            r_len  <= n_len;
            r_ovf  <= n_ovf;
            r_seed <= n_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i_en && (i_item.kind == KIND_APPEND) && (r_len == LEN_W'(i))) begin
                r_pat[i] <= i_item.byte_value;
            end
        end
    end

    assign o_result.matched          = reach[r_len] && !r_ovf;
    assign o_result.pattern_overflow = r_ovf;

endmodule

>>> hw/rtl/wgm_out_stage.sv
module wgm_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wgm_pkg::t_result i_result,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output wgm_pkg::t_result o_result
);
    import wgm_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> hw/rtl/wildcard_glob_matcher_top.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_kind, i_byte_value
// result    out        o_valid / i_ready  o_matched, o_pattern_overflow
//
// Every beat is taken into an input register and processed from there, so one beat
// per cycle is sustained while no end-of-name beat waits. The result of an
// end-of-name beat passes from the input register into the result register.
// The reach update of all pattern positions at once sets this rate.
// Reset is synchronous and empties the pattern. While the result register is
// full and not taken, the next end-of-name beat waits, and every beat behind it.
module wildcard_glob_matcher_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_byte_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_matched,
    output logic                o_pattern_overflow
);
    import wgm_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    advance;
    logic    out_can_load;
    t_result core_result;
    t_result out_result;

    assign advance = r_in_valid && ((r_in_item.kind != KIND_END) || out_can_load);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_item.kind       <= i_kind;
            r_in_item.byte_value <= i_byte_value;
        end
    end

    wgm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .o_result (core_result)
    );

    wgm_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && (r_in_item.kind == KIND_END)),
        .i_result   (core_result),
        .o_can_load (out_can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_result)
    );

    assign o_matched          = out_result.matched;
    assign o_pattern_overflow = out_result.pattern_overflow;

endmodule
